// ----- src/pfcp_pkg.sv -----
// ----------------------------------------------------------------------------
// pfcp_pkg
// Shared types, constants and helpers for the pixel format converter.
// ----------------------------------------------------------------------------
package pfcp_pkg;

	localparam int PIX_W  = 8;
	localparam int MODE_W = 2;
	localparam int COEF_W = 16;
	localparam int PROD_W = COEF_W + PIX_W + 1;
	localparam int SUM_W  = PROD_W + 1;
	localparam int FRAC_W = 15;

	localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 8'd255;
	localparam logic [PIX_W-1:0] Y_OFFSET     = 8'd16;
	localparam logic [PIX_W-1:0] C_OFFSET     = 8'd128;

	// BT.601 studio range, scaled by 2^15
	localparam logic signed [COEF_W-1:0] K_Y_R  = 16'sd8432;
	localparam logic signed [COEF_W-1:0] K_Y_G  = 16'sd16425;
	localparam logic signed [COEF_W-1:0] K_Y_B  = 16'sd3176;
	localparam logic signed [COEF_W-1:0] K_CB_R = -16'sd4818;
	localparam logic signed [COEF_W-1:0] K_CB_G = -16'sd9527;
	localparam logic signed [COEF_W-1:0] K_CB_B = 16'sd14345;
	localparam logic signed [COEF_W-1:0] K_CR_R = 16'sd14345;
	localparam logic signed [COEF_W-1:0] K_CR_G = -16'sd12045;
	localparam logic signed [COEF_W-1:0] K_CR_B = -16'sd2300;

	typedef enum logic [MODE_W-1:0] {
		MODE_BGR     = 2'd0,
		MODE_BGRA_PM = 2'd1,
		MODE_YCC     = 2'd2,
		MODE_YCC_PM  = 2'd3
	} mode_t;

	typedef struct packed {
		logic s1;
		logic s2;
	} stage_en_t;

	function automatic logic signed [PROD_W-1:0] coef_mul(
		input logic signed [COEF_W-1:0] k,
		input logic [PIX_W-1:0] x
	);
		return PROD_W'(k) * PROD_W'($signed({1'b0, x}));
	endfunction

	// divide by 2^15 truncating toward zero, add offset, keep 8 bits
	function automatic logic [PIX_W-1:0] ycc_scale(
		input logic signed [PROD_W-1:0] p0,
		input logic signed [PROD_W-1:0] p1,
		input logic signed [PROD_W-1:0] p2,
		input logic [PIX_W-1:0] off
	);
		logic signed [SUM_W-1:0] sum;
		logic signed [SUM_W-1:0] adj;
		sum = SUM_W'(p0) + SUM_W'(p1) + SUM_W'(p2);
		adj = sum[SUM_W-1] ? sum + SUM_W'((1 << FRAC_W) - 1) : sum;
		return PIX_W'(adj >>> FRAC_W) + off;
	endfunction

	function automatic logic [PIX_W-1:0] premul(
		input logic [PIX_W-1:0] c,
		input logic [PIX_W-1:0] a
	);
		logic [2*PIX_W-1:0] p;
		p = (2*PIX_W)'(c) * (2*PIX_W)'(a);
		return p[2*PIX_W-1:PIX_W];
	endfunction

endpackage

// ----- src/pfcp_ycc.sv -----
// ----------------------------------------------------------------------------
// pfcp_ycc
// Two-stage RGB to YCbCr matrix: products in s1, sums and scaling in s2.
// ----------------------------------------------------------------------------
module pfcp_ycc import pfcp_pkg::*; (
	input  logic             clk,
	input  stage_en_t        en,
	input  logic [PIX_W-1:0] blue,
	input  logic [PIX_W-1:0] green,
	input  logic [PIX_W-1:0] red,
	output logic [PIX_W-1:0] y_s2,
	output logic [PIX_W-1:0] cb_s2,
	output logic [PIX_W-1:0] cr_s2
);

	logic signed [PROD_W-1:0] y_r_s1, y_g_s1, y_b_s1;
	logic signed [PROD_W-1:0] cb_r_s1, cb_g_s1, cb_b_s1;
	logic signed [PROD_W-1:0] cr_r_s1, cr_g_s1, cr_b_s1;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			y_r_s1  <= coef_mul(K_Y_R, red);
			y_g_s1  <= coef_mul(K_Y_G, green);
			y_b_s1  <= coef_mul(K_Y_B, blue);
			cb_r_s1 <= coef_mul(K_CB_R, red);
			cb_g_s1 <= coef_mul(K_CB_G, green);
			cb_b_s1 <= coef_mul(K_CB_B, blue);
			cr_r_s1 <= coef_mul(K_CR_R, red);
			cr_g_s1 <= coef_mul(K_CR_G, green);
			cr_b_s1 <= coef_mul(K_CR_B, blue);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			y_s2  <= ycc_scale(y_r_s1, y_g_s1, y_b_s1, Y_OFFSET);
			cb_s2 <= ycc_scale(cb_r_s1, cb_g_s1, cb_b_s1, C_OFFSET);
			cr_s2 <= ycc_scale(cr_r_s1, cr_g_s1, cr_b_s1, C_OFFSET);
		end
	end

endmodule

// ----- src/pixel_format_converter_premultiply.sv -----
// ----------------------------------------------------------------------------
// pixel_format_converter_premultiply
// BGRA pixel to BGR/BGRA/YCbCr with optional alpha premultiply.
// ----------------------------------------------------------------------------
// One pixel in, one pixel out. Three-stage pipeline (coefficient products,
// matrix sum and scaling, premultiply); a new pixel is taken every cycle
// unless the output stalls, and each stage holds while the one after it
// is full and stalled. conversion_mode is written through cfg_valid/cfg_ready
// (always ready) and must only change while the pipeline is empty.
module pixel_format_converter_premultiply import pfcp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [MODE_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [PIX_W-1:0]  blue,
	input  logic [PIX_W-1:0]  green,
	input  logic [PIX_W-1:0]  red,
	input  logic [PIX_W-1:0]  alpha_in,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PIX_W-1:0]  first_channel,
	output logic [PIX_W-1:0]  second_channel,
	output logic [PIX_W-1:0]  third_channel,
	output logic [PIX_W-1:0]  alpha_out
);

	mode_t mode_q;

	logic valid_s1, valid_s2, valid_s3;
	logic rdy1, rdy2, rdy3;
	stage_en_t en;

	mode_t            mode_s1, mode_s2;
	logic [PIX_W-1:0] b_s1, g_s1, r_s1, a_s1;
	logic [PIX_W-1:0] c0_s2, c1_s2, c2_s2, a_s2;
	logic [PIX_W-1:0] y_s2, cb_s2, cr_s2;
	logic [PIX_W-1:0] c0_s3, c1_s3, c2_s3, a_s3;

	logic             ycc_s2, pm_s2;
	logic [PIX_W-1:0] c0_mux, c1_mux, c2_mux;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BGR;
		end else if (cfg_valid) begin
			mode_q <= mode_t'(cfg_data);
		end
	end

	assign rdy3     = !valid_s3 || !out_stall;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_stall = !rdy1;
	assign en.s1    = rdy1;
	assign en.s2    = rdy2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			mode_s1 <= mode_q;
			b_s1    <= blue;
			g_s1    <= green;
			r_s1    <= red;
			a_s1    <= alpha_in;
		end
		if (rdy2) begin
			mode_s2 <= mode_s1;
			c0_s2   <= b_s1;
			c1_s2   <= g_s1;
			c2_s2   <= r_s1;
			a_s2    <= a_s1;
		end
	end

	pfcp_ycc u_ycc (
		.clk   (clk),
		.en    (en),
		.blue  (blue),
		.green (green),
		.red   (red),
		.y_s2  (y_s2),
		.cb_s2 (cb_s2),
		.cr_s2 (cr_s2)
	);

	always_comb begin
		ycc_s2 = (mode_s2 == MODE_YCC) || (mode_s2 == MODE_YCC_PM);
		pm_s2  = (mode_s2 == MODE_BGRA_PM) || (mode_s2 == MODE_YCC_PM);
		c0_mux = ycc_s2 ? y_s2  : c0_s2;
		c1_mux = ycc_s2 ? cb_s2 : c1_s2;
		c2_mux = ycc_s2 ? cr_s2 : c2_s2;
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			if (pm_s2 && (a_s2 != ALPHA_OPAQUE)) begin
				c0_s3 <= premul(c0_mux, a_s2);
				c1_s3 <= premul(c1_mux, a_s2);
				c2_s3 <= premul(c2_mux, a_s2);
			end else begin
				c0_s3 <= c0_mux;
				c1_s3 <= c1_mux;
				c2_s3 <= c2_mux;
			end
			a_s3 <= pm_s2 ? a_s2 : ALPHA_OPAQUE;
		end
	end

	assign out_valid      = valid_s3;
	assign first_channel  = c0_s3;
	assign second_channel = c1_s3;
	assign third_channel  = c2_s3;
	assign alpha_out      = a_s3;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives BGRA pixels through pixel_format_converter_premultiply in every
// conversion mode. A behavioral converter predicts each output pixel, and
// a scoreboard checks the outputs in order under random idle and stall.
// ----------------------------------------------------------------------------
module testbench;
	import pfcp_pkg::*;

	localparam int CLK_PERIOD  = 20;
	localparam int DRAIN_WAIT  = 6;
	localparam int IDLE_LIMIT  = 5000;

	typedef struct packed {
		logic [PIX_W-1:0] first;
		logic [PIX_W-1:0] second;
		logic [PIX_W-1:0] third;
		logic [PIX_W-1:0] alpha;
	} pixel_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [MODE_W-1:0] cfg_data;
	logic              in_valid;
	logic              in_stall;
	logic [PIX_W-1:0]  blue;
	logic [PIX_W-1:0]  green;
	logic [PIX_W-1:0]  red;
	logic [PIX_W-1:0]  alpha_in;
	logic              out_valid;
	logic              out_stall;
	logic [PIX_W-1:0]  first_channel;
	logic [PIX_W-1:0]  second_channel;
	logic [PIX_W-1:0]  third_channel;
	logic [PIX_W-1:0]  alpha_out;

	mode_t  cur_mode;
	pixel_t expected_pixels[$];
	int     error_count;
	int     send_idle_pct;
	int     recv_stall_pct;
	int     recv_hold_left;
	int     quiet_cycles;

	pixel_format_converter_premultiply u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.blue           (blue),
		.green          (green),
		.red            (red),
		.alpha_in       (alpha_in),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.first_channel  (first_channel),
		.second_channel (second_channel),
		.third_channel  (third_channel),
		.alpha_out      (alpha_out)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic pixel_t convert_pixel(mode_t mode, logic [PIX_W-1:0] b,
		logic [PIX_W-1:0] g, logic [PIX_W-1:0] r, logic [PIX_W-1:0] a);
		int     bi;
		int     gi;
		int     ri;
		int     ai;
		int     c0;
		int     c1;
		int     c2;
		pixel_t px;
		bi = b;
		gi = g;
		ri = r;
		ai = a;
		if (mode == MODE_YCC || mode == MODE_YCC_PM) begin
			c0 = (8432 * ri + 16425 * gi + 3176 * bi) / 32768 + 16;
			c1 = (-4818 * ri - 9527 * gi + 14345 * bi) / 32768 + 128;
			c2 = (14345 * ri - 12045 * gi - 2300 * bi) / 32768 + 128;
		end else begin
			c0 = bi;
			c1 = gi;
			c2 = ri;
		end
		c0 = c0 & 255;
		c1 = c1 & 255;
		c2 = c2 & 255;
		if (mode == MODE_BGRA_PM || mode == MODE_YCC_PM) begin
			if (ai < 255) begin
				c0 = ((c0 * ai) >> 8) & 255;
				c1 = ((c1 * ai) >> 8) & 255;
				c2 = ((c2 * ai) >> 8) & 255;
			end
			px.alpha = a;
		end else begin
			px.alpha = ALPHA_OPAQUE;
		end
		px.first  = c0[PIX_W-1:0];
		px.second = c1[PIX_W-1:0];
		px.third  = c2[PIX_W-1:0];
		return px;
	endfunction

	// input beat accepted: predict its output pixel
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			expected_pixels.push_back(convert_pixel(cur_mode, blue, green, red, alpha_in));
	end

	always @(posedge clk) begin
		pixel_t exp_px;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pixels.size() == 0) begin
				$error("unexpected output beat: %0d %0d %0d %0d",
					first_channel, second_channel, third_channel, alpha_out);
				error_count++;
			end else begin
				exp_px = expected_pixels.pop_front();
				if (first_channel !== exp_px.first) begin
					$error("first_channel: expected %0d, got %0d", exp_px.first, first_channel);
					error_count++;
				end
				if (second_channel !== exp_px.second) begin
					$error("second_channel: expected %0d, got %0d", exp_px.second,
						second_channel);
					error_count++;
				end
				if (third_channel !== exp_px.third) begin
					$error("third_channel: expected %0d, got %0d", exp_px.third, third_channel);
					error_count++;
				end
				if (alpha_out !== exp_px.alpha) begin
					$error("alpha_out: expected %0d, got %0d", exp_px.alpha, alpha_out);
					error_count++;
				end
			end
		end
	end

	// output side: random stall, or a long hold-off when requested
	always @(negedge clk) begin
		if (recv_hold_left > 0) begin
			out_stall <= 1'b1;
			recv_hold_left <= recv_hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic send_pixel(logic [PIX_W-1:0] b, logic [PIX_W-1:0] g,
		logic [PIX_W-1:0] r, logic [PIX_W-1:0] a);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		blue     <= b;
		green    <= g;
		red      <= r;
		alpha_in <= a;
		do @(posedge clk); while (in_stall);
	endtask

	function automatic logic [PIX_W-1:0] pick_color();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	function automatic logic [PIX_W-1:0] pick_alpha();
		case ($urandom_range(7))
			0, 1:    return ALPHA_OPAQUE;
			2:       return '0;
			3:       return ALPHA_OPAQUE - 8'd1;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	task automatic send_random_pixel();
		send_pixel(pick_color(), pick_color(), pick_color(), pick_alpha());
	endtask

	task automatic drain_pipeline();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_mode(mode_t mode);
		drain_pipeline();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= mode;
		do @(posedge clk); while (!cfg_ready);
		cur_mode = mode;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_directed();
		mode_t modes[4];
		modes = '{MODE_BGR, MODE_BGRA_PM, MODE_YCC, MODE_YCC_PM};
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		// reset mode first, before any write
		send_pixel(8'd10, 8'd20, 8'd30, 8'd40);
		foreach (modes[i]) begin
			write_mode(modes[i]);
			send_pixel(8'd0,   8'd0,   8'd0,   8'd0);
			send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
			send_pixel(8'd255, 8'd255, 8'd255, 8'd254);
			send_pixel(8'd0,   8'd0,   8'd255, 8'd128);
			send_pixel(8'd255, 8'd0,   8'd0,   8'd1);
			send_pixel(8'd0,   8'd255, 8'd0,   8'd255);
		end
		drain_pipeline();
	endtask

	task automatic test_random(int count, int idle_pct, int stall_pct);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int n = 0; n < count; n++) begin
			if (n % 45 == 0)
				write_mode(mode_t'($urandom_range(3)));
			send_random_pixel();
		end
		drain_pipeline();
	endtask

	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		write_mode(MODE_YCC_PM);
		recv_hold_left = 60;
		for (int n = 0; n < 24; n++)
			send_random_pixel();
		// pause until everything is out
		drain_pipeline();
		write_mode(MODE_BGRA_PM);
		recv_hold_left = 40;
		for (int n = 0; n < 16; n++)
			send_random_pixel();
		drain_pipeline();
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		cfg_data       = '0;
		in_valid       = 1'b0;
		blue           = '0;
		green          = '0;
		red            = '0;
		alpha_in       = '0;
		out_stall      = 1'b0;
		cur_mode       = MODE_BGR;
		error_count    = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		recv_hold_left = 0;
		quiet_cycles   = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random(160, 29, 48);
		test_random(160, 48, 29);
		test_random(160, 0, 0);
		test_backpressure();

		drain_pipeline();
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- pixel_format_converter_premultiply.f -----
src/pfcp_pkg.sv
src/pfcp_ycc.sv
src/pixel_format_converter_premultiply.sv
tb/testbench.sv
